>>> hw/rtl/cross_erosion_binarize_assert.svh
// Assertion macros shared by the erosion block.
// Needs a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef CROSS_EROSION_BINARIZE_ASSERT_SVH
`define CROSS_EROSION_BINARIZE_ASSERT_SVH

// Same-cycle implication
`define CEB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define CEB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/ceb_pkg.sv
// Package for the cross erosion block: sizes, register indexes, result codes.
// No dependencies; used by the interfaces and by the top level.
package ceb_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 12;
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 11;
    localparam int CFG_IDX_W  = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [DIM_W-1:0] DIM_MIN      = 12'd3;

    localparam logic [PIX_W-1:0] PIX_ON  = 8'd255;
    localparam logic [PIX_W-1:0] PIX_OFF = 8'd0;

    // line store entry: upper line bit and middle line bit
    typedef struct packed {
        logic upper;
        logic middle;
    } t_line_bits;

    // item held between the read issue and the result register
    typedef struct packed {
        logic               emit;
        logic               last;
        logic               right_ok;
        logic               cur;
        logic [ADDR_W-1:0]  col;
        logic [ROW_W-1:0]   row;
    } t_stage;

endpackage

>>> hw/rtl/ceb_pix_if.sv
// Input pixel channel: valid/ready plus one pixel word.
// Depends on ceb_pkg.
interface ceb_pix_if import ceb_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

>>> hw/rtl/ceb_res_if.sv
// Result channel: valid/ready plus one eroded pixel word with its position.
// Depends on ceb_pkg.
interface ceb_res_if import ceb_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   out_value;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               frame_last;

    modport source (output valid, output out_value, output out_row, output out_col,
                    output frame_last, input ready);
    modport sink   (input valid, input out_value, input out_row, input out_col,
                    input frame_last, output ready);
endinterface

>>> hw/rtl/ceb_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on ceb_pkg.
interface ceb_cfg_if import ceb_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/ceb_ram.sv
// Generic RAM: one write port, two registered read ports, old data on collision.
// No dependencies.
module ceb_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

>>> hw/rtl/cross_erosion_binarize.sv
// Cross-shaped 3x3 binary erosion of a raster grayscale stream. Each pixel is
// reduced to a nonzero bit; one pixel word is accepted per clock unless the
// result channel stalls or the line store is being cleared. A result (255 or 0)
// for an interior centre pixel passes the line store read and the result register
// once the pixel directly below it is accepted. Border pixels give no result;
// frame_last marks the result for the last interior pixel. After reset the line
// store is cleared, one entry per clock, and the input is held off until all
// MAX_WIDTH (2048) entries are done; configuration writes are taken at any time.
// Configuration should only be written while no pixel is in flight.
// Depends on ceb_pkg, the channel interfaces, ceb_ram and the assertion header.
`include "cross_erosion_binarize_assert.svh"

module cross_erosion_binarize import ceb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ceb_pix_if.sink     i_pix,
    ceb_res_if.source   o_res,
    ceb_cfg_if.sink     i_cfg
);

    // configuration registers
    logic [DIM_W-1:0] r_width, r_height;
    logic [DIM_W-1:0] wc, hc;

    // counters and clearing pass
    logic [ADDR_W-1:0] r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // stage register, forwarding and left neighbour
    t_stage            r_s1, n_s1;
    logic              r_s1_vld;
    logic              r_fwd_vld;
    logic [ADDR_W-1:0] r_fwd_addr;
    t_line_bits        r_fwd_data;
    logic              r_left;

    // result register
    logic               r_out_vld;
    logic [PIX_W-1:0]   r_out_value;
    logic [COORD_W-1:0] r_out_row, r_out_col;
    logic               r_out_last;

    // handshake terms
    logic in_acc, s1_adv, slot_free;

    // stage 0 position logic
    logic [ADDR_W-1:0] c0, cc;
    logic [ROW_W-1:0]  r0, rr;
    logic [DIM_W-1:0]  r1, cp1, cp2, rp1;
    logic              col_wrap;

    // stage 1 data
    t_line_bits        q_a, q_b, e_a, e_b;
    logic [ADDR_W-1:0] addr_b1;
    logic              up, centre, right, all_set;

    // RAM ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    t_line_bits        ram_wdata;

    // clamp the configured dimensions
    always_comb begin
        if (r_width < DIM_MIN) begin
            wc = DIM_MIN;
        end else if (r_width > DIM_W'(MAX_WIDTH)) begin
            wc = DIM_W'(MAX_WIDTH);
        end else begin
            wc = r_width;
        end
        if (r_height < DIM_MIN) begin
            hc = DIM_MIN;
        end else if (r_height > DIM_W'(MAX_HEIGHT)) begin
            hc = DIM_W'(MAX_HEIGHT);
        end else begin
            hc = r_height;
        end
    end

    // configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg.data;
                CFG_IMAGE_HEIGHT: r_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // handshake
    assign slot_free   = !r_out_vld || o_res.ready;
    assign s1_adv      = r_s1_vld && (!r_s1.emit || slot_free);
    assign i_pix.ready = !r_clr_busy && (!r_s1_vld || s1_adv);
    assign in_acc      = i_pix.valid && i_pix.ready;

    // stage 0: position of this pixel, next counters, result flags
    always_comb begin
        c0       = i_pix.frame_start ? '0 : r_col;
        r0       = i_pix.frame_start ? '0 : r_row;
        col_wrap = DIM_W'(c0) >= wc;
        r1       = col_wrap ? DIM_W'(r0) + DIM_W'(1) : DIM_W'(r0);
        rr       = (r1 >= hc) ? '0 : r1[ROW_W-1:0];
        cc       = col_wrap ? '0 : c0;
        cp1      = DIM_W'(cc) + DIM_W'(1);
        cp2      = DIM_W'(cc) + DIM_W'(2);
        rp1      = DIM_W'(rr) + DIM_W'(1);
        if (cp1 >= wc) begin
            n_col = '0;
            n_row = (rp1 >= hc) ? '0 : rp1[ROW_W-1:0];
        end else begin
            n_col = cp1[ADDR_W-1:0];
            n_row = rr;
        end
        n_s1.emit     = (rr >= ROW_W'(2)) && (cc != '0) && (cp2 <= wc);
        n_s1.last     = (rp1 == hc) && (cp2 == wc);
        n_s1.right_ok = cp1 < wc;
        n_s1.cur      = i_pix.pixel != '0;
        n_s1.col      = cc;
        n_s1.row      = rr;
    end

    // counters, stage register and forwarding record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_s1_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_left    <= 1'b0;
        end else begin
            if (in_acc) begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_fwd_vld <= s1_adv;
            end
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_left <= centre;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1       <= n_s1;
            r_fwd_addr <= ram_waddr;
            r_fwd_data <= ram_wdata;
        end
    end

    // clearing pass over the line store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(MAX_WIDTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // line store: write from clearing pass or from the retiring item
    always_comb begin
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we           = s1_adv;
            ram_waddr        = r_s1.col;
            ram_wdata.upper  = centre;
            ram_wdata.middle = r_s1.cur;
        end
    end

    ceb_ram #(
        .WIDTH ($bits(t_line_bits)),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re      (in_acc),
        .i_raddr_a (cc),
        .i_raddr_b (cp1[ADDR_W-1:0]),
        .o_rdata_a (q_a),
        .o_rdata_b (q_b)
    );

    // stage 1: forward a write that coincided with the read, then erode
    always_comb begin
        addr_b1 = r_s1.col + ADDR_W'(1);
        e_a     = (r_fwd_vld && r_fwd_addr == r_s1.col) ? r_fwd_data : q_a;
        e_b     = (r_fwd_vld && r_fwd_addr == addr_b1) ? r_fwd_data : q_b;
        up      = e_a.upper;
        centre  = e_a.middle;
        right   = r_s1.right_ok && e_b.middle;
        all_set = up && r_left && centre && right && r_s1.cur;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv && r_s1.emit) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1.emit) begin
            r_out_value <= all_set ? PIX_ON : PIX_OFF;
            r_out_row   <= COORD_W'(r_s1.row - ROW_W'(1));
            r_out_col   <= COORD_W'(r_s1.col);
            r_out_last  <= r_s1.last;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.out_value  = r_out_value;
    assign o_res.out_row    = r_out_row;
    assign o_res.out_col    = r_out_col;
    assign o_res.frame_last = r_out_last;

    // checks
    `CEB_ASSERT_NOW(a_no_pix_during_clear, r_clr_busy, !i_pix.ready)
    `CEB_ASSERT_NOW(a_no_item_during_clear, r_clr_busy, !r_s1_vld)
    `CEB_ASSERT_NOW(a_no_result_overwrite, s1_adv && r_s1.emit, slot_free)
    `CEB_ASSERT_NOW(a_binary_value, r_out_vld,
        r_out_value == PIX_ON || r_out_value == PIX_OFF)
    `CEB_ASSERT_NEXT(a_result_follows, s1_adv && r_s1.emit, r_out_vld)

endmodule
